// File: rtl/ps2mt_pkg.sv
// Package for the PS/2 mouse packet tracker.
// Holds the payload structs, the command passed between front and back, and constants.
// No dependencies.
package ps2mt_pkg;

    // Controller status gate: output full (bit 0) and aux data (bit 5).
    localparam logic [7:0] GATE_MASK   = 8'h21;
    localparam int         SYNC_BIT    = 3;
    localparam int         BUTTON_W    = 3;

    // Cursor size kept clear of the far edges.
    localparam int CURSOR_W = 12;
    localparam int CURSOR_H = 12;

    localparam int POS_W   = 12;
    localparam int BOUND_W = 13;
    localparam int POS_MAX = 4095;

    // Bound registers and their reset values.
    localparam int                 CFG_INDEX_W  = 1;
    localparam logic [BOUND_W-1:0] WIDTH_RESET  = 13'd1280;
    localparam logic [BOUND_W-1:0] HEIGHT_RESET = 13'd800;
    localparam logic [POS_W-1:0]   X_RESET      = POS_W'(WIDTH_RESET / 2);
    localparam logic [POS_W-1:0]   Y_RESET      = POS_W'(HEIGHT_RESET / 2);

    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Position of the next byte within a three-byte packet.
    typedef enum logic [1:0] {
        PHASE_FIRST  = 2'd0,
        PHASE_SECOND = 2'd1,
        PHASE_THIRD  = 2'd2
    } packet_phase_t;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] data_byte;
    } mouse_in_t;

    typedef struct packed {
        logic                byte_taken;
        logic                report_valid;
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic signed [7:0]   delta_x;
        logic signed [7:0]   delta_y;
        logic [BUTTON_W-1:0] buttons;
    } mouse_out_t;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic                taken;
        logic                report;
        logic [7:0]          dx;
        logic [7:0]          ndy;
        logic [BUTTON_W-1:0] buttons;
    } ps2mt_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ps2mt_q_status_t;

endpackage

// File: rtl/ps2mt_front.sv
// Front end of the PS/2 mouse packet tracker: gates the status byte and assembles packets.
// Depends on ps2mt_pkg.
module ps2mt_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  ps2mt_pkg::mouse_in_t   in_data,
    output ps2mt_pkg::ps2mt_cmd_t  cmd
);
    import ps2mt_pkg::*;

    packet_phase_t phase_reg, phase_next;
    logic [7:0]    first_byte_reg, first_byte_next;
    logic [7:0]    second_byte_reg, second_byte_next;
    logic          gate;

    // The data byte counts only when the controller flags aux output full.
    assign gate = ((in_data.status_byte & GATE_MASK) == GATE_MASK);

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PHASE_FIRST;
            first_byte_reg  <= 8'd0;
            second_byte_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            first_byte_reg  <= first_byte_next;
            second_byte_reg <= second_byte_next;
        end
    end

    // Next packet phase and the command for this byte.
    always_comb
    begin
        phase_next       = phase_reg;
        first_byte_next  = first_byte_reg;
        second_byte_next = second_byte_reg;
        cmd.taken        = gate;
        cmd.report       = 1'b0;
        cmd.dx           = second_byte_reg;
        cmd.ndy          = 8'd0 - in_data.data_byte;
        cmd.buttons      = first_byte_reg[BUTTON_W-1:0];
        case (phase_reg)
            PHASE_FIRST:
            begin
                // A first byte without the sync bit is dropped to resync.
                if (gate && in_data.data_byte[SYNC_BIT])
                begin
                    first_byte_next = in_data.data_byte;
                    phase_next      = PHASE_SECOND;
                end
            end
            PHASE_SECOND:
            begin
                if (gate)
                begin
                    second_byte_next = in_data.data_byte;
                    phase_next       = PHASE_THIRD;
                end
            end
            default:
            begin
                if (gate)
                begin
                    cmd.report = 1'b1;
                    phase_next = PHASE_FIRST;
                end
            end
        endcase
    end

endmodule

// File: rtl/ps2mt_queue.sv
// Short command queue between front and back of the PS/2 mouse packet tracker.
// Depends on ps2mt_pkg.
module ps2mt_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  ps2mt_pkg::ps2mt_cmd_t       push_cmd,
    input  logic                        pop,
    output ps2mt_pkg::ps2mt_cmd_t       head_cmd,
    output ps2mt_pkg::ps2mt_q_status_t  status
);
    import ps2mt_pkg::*;

    ps2mt_cmd_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/ps2mt_back.sv
// Back end of the PS/2 mouse packet tracker: applies deltas, clamps and holds the result.
// Depends on ps2mt_pkg.
module ps2mt_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [ps2mt_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ps2mt_pkg::BOUND_W-1:0]          cfg_wdata,
    input  logic                                   cmd_valid,
    input  ps2mt_pkg::ps2mt_cmd_t                  cmd,
    output logic                                   pop,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output ps2mt_pkg::mouse_out_t                  out_data
);
    import ps2mt_pkg::*;

    logic [BOUND_W-1:0]  width_reg, height_reg;
    logic [POS_W-1:0]    pos_x_reg, pos_x_next;
    logic [POS_W-1:0]    pos_y_reg, pos_y_next;
    logic [7:0]          dx_reg, dy_reg;
    logic [BUTTON_W-1:0] buttons_reg;
    logic                taken_reg, report_reg;
    logic                valid_reg;

    // Move one axis, clamp below at zero and above at bound minus size minus one and at POS_MAX.
    function automatic logic [POS_W-1:0] axis_move(
        input logic [POS_W-1:0]   pos,
        input logic [7:0]         d,
        input logic [BOUND_W-1:0] bound,
        input logic [6:0]         size
    );
        logic signed [14:0] p;
        logic signed [14:0] lim;
        p   = signed'({3'b000, pos}) + signed'({{7{d[7]}}, d});
        lim = signed'({2'b00, bound}) - signed'({8'd0, size});
        if (p < 0)
            p = '0;
        if (p >= lim)
            p = lim - 15'sd1;
        if (p < 0)
            p = '0;
        if (p > 15'(POS_MAX))
            p = 15'(POS_MAX);
        return p[POS_W-1:0];
    endfunction

    assign pos_x_next = axis_move(pos_x_reg, cmd.dx, width_reg, 7'(CURSOR_W));
    assign pos_y_next = axis_move(pos_y_reg, cmd.ndy, height_reg, 7'(CURSOR_H));

    // A command moves on when the output slot is free or being emptied.
    assign pop       = cmd_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;

    assign out_data.byte_taken   = taken_reg;
    assign out_data.report_valid = report_reg;
    assign out_data.pos_x        = pos_x_reg;
    assign out_data.pos_y        = pos_y_reg;
    assign out_data.delta_x      = signed'(dx_reg);
    assign out_data.delta_y      = signed'(dy_reg);
    assign out_data.buttons      = buttons_reg;

    // Bound registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Pointer state, which doubles as the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            taken_reg   <= 1'b0;
            report_reg  <= 1'b0;
            pos_x_reg   <= X_RESET;
            pos_y_reg   <= Y_RESET;
            dx_reg      <= 8'd0;
            dy_reg      <= 8'd0;
            buttons_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg  <= 1'b1;
                taken_reg  <= cmd.taken;
                report_reg <= cmd.report;
                if (cmd.report)
                begin
                    pos_x_reg   <= pos_x_next;
                    pos_y_reg   <= pos_y_next;
                    dx_reg      <= cmd.dx;
                    dy_reg      <= cmd.ndy;
                    buttons_reg <= cmd.buttons;
                end
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/ps2mt_tracker_top.sv
// Top level of the PS/2 mouse packet tracker: front, command queue and back.
// Depends on ps2mt_pkg, ps2mt_front, ps2mt_queue and ps2mt_back.
//
// Each accepted transaction carries one controller status byte and one data
// byte and yields exactly one result transaction. The block takes one
// transaction per clock while the queue is not full; the result is held in
// the two-entry command queue that follows the packet assembler, then in the
// back end, whose position, delta and button registers are the output
// register. The back end applies one command per cycle (one add, compare and
// clamp per axis) unless out_ready holds it, so that stage sets the rate.
// The user must write the bound registers through the plain write port only
// while the block is idle, which it does not enforce; a new bound takes effect
// at the next completed packet. The pointer starts at the reset bounds' center.
module ps2_mouse_packet_tracker_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ps2mt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ps2mt_pkg::BOUND_W-1:0]      cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  ps2mt_pkg::mouse_in_t               in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ps2mt_pkg::mouse_out_t              out_data
);
    import ps2mt_pkg::*;

    logic            accept;
    logic            pop;
    ps2mt_cmd_t      front_cmd;
    ps2mt_cmd_t      head_cmd;
    ps2mt_q_status_t q_status;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    ps2mt_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_data (in_data),
        .cmd     (front_cmd)
    );

    ps2mt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    ps2mt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (!q_status.empty),
        .cmd       (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // The back end never drains an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

    // A completed packet always comes from a byte that passed the gate.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!out_data.report_valid || out_data.byte_taken))
        else $error("report without a taken byte");

    // The pointer moves only when a packet completes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && head_cmd.report) |=> ($stable(out_data.pos_x) && $stable(out_data.pos_y)))
        else $error("pointer moved without a completed packet");

    // A full queue holds back the input side.
    assert property (@(posedge clk) disable iff (!rst_n) q_status.full |-> !accept)
        else $error("transaction accepted into a full queue");
`endif

endmodule
